// File: src/sha_pkg.sv
// Package: SHA-256 constants, mode, word and round-unit port types, and helper functions.
package sha_pkg;

    typedef enum logic [1:0] {
        MODE_ABSORB   = 2'd0,
        MODE_FINALIZE = 2'd1,
        MODE_RESTART  = 2'd2,
        MODE_UNUSED   = 2'd3
    } mode_t;

    typedef logic [31:0] word_t;

    // Command from the controller to the round unit
    typedef struct packed {
        logic start;
        logic init;
    } rnd_ctrl_t;

    // Status from the round unit
    typedef struct packed {
        logic busy;
        logic done;
    } rnd_stat_t;

    function automatic word_t round_k(input logic [5:0] idx);
        word_t k;
        unique case (idx)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic word_t init_h(input logic [2:0] idx);
        word_t h;
        unique case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic word_t ror32(input word_t v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage

// File: src/sha_round.sv
// Round unit: one SHA-256 round per cycle over a 16-word schedule window.
module sha_round
    import sha_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  rnd_ctrl_t   ctrl,
    input  word_t       w_in,       // block word loaded during rounds 0..15
    input  word_t       hash_in [8],
    output rnd_stat_t   stat,
    output word_t       work_out [8]
);

    word_t       wv_reg [8];
    word_t       win_reg [16];
    logic [5:0]  rnd_reg;
    logic        busy_reg;
    logic        done_reg;

    word_t w_cur, s0, s1, t1, t2, w_new;

    // Schedule word for this round
    always_comb begin
        s0 = ror32(win_reg[1], 7) ^ ror32(win_reg[1], 18) ^ (win_reg[1] >> 3);
        s1 = ror32(win_reg[14], 17) ^ ror32(win_reg[14], 19) ^ (win_reg[14] >> 10);
        w_new = win_reg[0] + s0 + win_reg[9] + s1;
        w_cur = (rnd_reg < 6'd16) ? w_in : w_new;
        t1 = wv_reg[7] + (ror32(wv_reg[4], 6) ^ ror32(wv_reg[4], 11) ^ ror32(wv_reg[4], 25))
           + ((wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6])) + round_k(rnd_reg) + w_cur;
        t2 = (ror32(wv_reg[0], 2) ^ ror32(wv_reg[0], 13) ^ ror32(wv_reg[0], 22))
           + ((wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]));
    end

    // Advance one round per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
            end else if (busy_reg) begin
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            for (int i = 0; i < 8; i++) wv_reg[i] <= hash_in[i];
        end else if (busy_reg) begin
            wv_reg[7] <= wv_reg[6];
            wv_reg[6] <= wv_reg[5];
            wv_reg[5] <= wv_reg[4];
            wv_reg[4] <= wv_reg[3] + t1;
            wv_reg[3] <= wv_reg[2];
            wv_reg[2] <= wv_reg[1];
            wv_reg[1] <= wv_reg[0];
            wv_reg[0] <= t1 + t2;
            for (int i = 0; i < 15; i++) win_reg[i] <= win_reg[i+1];
            win_reg[15] <= w_cur;
        end
    end

    assign stat.busy = busy_reg | ctrl.init;
    assign stat.done = done_reg;
    always_comb for (int i = 0; i < 8; i++) work_out[i] = wv_reg[i];

endmodule

// File: src/sha_ram.sv
// Generic single-port-write, registered-read RAM.
module sha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem_reg[waddr] <= wdata;
        rdata <= mem_reg[raddr];
    end

endmodule

// File: src/sha256_stream_hasher.sv
// Top level: SHA-256 byte-stream hasher with sequencer, block RAM and round unit.
//
// Absorb items are taken one per cycle while idle; the 64th byte of a block then
// holds off the input through a start state, a wait on the shared round unit
// (which runs its 64 rounds one per cycle from a word-wide block RAM) and an
// add of the result into the hash. Finalize writes padding one byte per cycle
// (up to 72 bytes over two padding blocks), runs one or two compressions and
// emits eight digest items (a repeated finalize only re-emits them); restart
// reloads the eight initial hash values. No clearing pass.
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
    output logic        m_tlast    // last_word
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_COMP = 7'b0000010,
        ST_WAIT = 7'b0000100,
        ST_PAD  = 7'b0001000,
        ST_ADD  = 7'b0010000,
        ST_EMIT = 7'b0100000,
        ST_INIT = 7'b1000000
    } state_t;

    state_t      state_reg;
    word_t       hash_reg [8];
    logic [5:0]  fill_reg;
    logic [60:0] len_reg;
    logic        done_reg;
    logic [5:0]  pos_reg;
    logic        final_reg;    // pad phase writes length and finishes
    logic        closing_reg;  // compression belongs to finalize
    logic [2:0]  idx_reg;
    logic [5:0]  rcnt_reg;
    logic [3:0]  init_reg;

    rnd_ctrl_t   rctrl;
    rnd_stat_t   rstat;
    word_t       work [8];
    word_t       ram_rdata;
    logic        ram_we;
    logic [3:0]  ram_waddr, ram_raddr;
    logic [1:0]  ram_lane;
    logic [7:0]  ram_byte;
    logic [31:0] ram_wdata;
    logic [63:0] bits;
    logic [3:0]  lane_we;

    logic acc;
    assign acc = s_tvalid & s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign bits = {len_reg, 3'b000};

    // Byte write source: absorb or padding
    always_comb begin
        ram_byte = s_tdata;
        ram_waddr = fill_reg[5:2];
        ram_lane = fill_reg[1:0];
        ram_we = acc && (mode_t'(s_tuser) == MODE_ABSORB) && !done_reg;
        if (state_reg == ST_PAD) begin
            ram_waddr = pos_reg[5:2];
            ram_lane = pos_reg[1:0];
            ram_we = 1'b1;
            if (pos_reg == fill_reg && !final_reg) ram_byte = 8'h80;
            else if (final_reg && pos_reg >= 6'd56)
                ram_byte = 8'(bits >> (6'(7) - 6'(pos_reg - 6'd56)) * 8);
            else ram_byte = 8'h00;
        end
        ram_wdata = {4{ram_byte}};
        lane_we = 4'b0001 << (2'd3 - ram_lane);
    end

    // Rounds 0..15 read word rcnt; read ahead by one for the registered RAM
    assign ram_raddr = (state_reg == ST_COMP) ? 4'd0 : 4'(rcnt_reg + 6'd1);

    // Four byte-lane RAMs form the 16-word block store
    for (genvar g = 0; g < 4; g++) begin : g_lane
        sha_ram #(.WIDTH(8), .DEPTH(16)) u_ram (
            .aclk  (aclk),
            .we    (ram_we & lane_we[g]),
            .waddr (ram_waddr),
            .wdata (ram_wdata[g*8 +: 8]),
            .raddr (ram_raddr),
            .rdata (ram_rdata[g*8 +: 8])
        );
    end

    assign rctrl.start = (state_reg == ST_COMP);
    assign rctrl.init  = 1'b0;

    sha_round u_round (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (rctrl),
        .w_in     (ram_rdata),
        .hash_in  (hash_reg),
        .stat     (rstat),
        .work_out (work)
    );

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            fill_reg <= '0;
            len_reg <= '0;
            done_reg <= 1'b0;
            idx_reg <= '0;
            init_reg <= '0;
            pos_reg <= '0;
            final_reg <= 1'b0;
            closing_reg <= 1'b0;
            rcnt_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_INIT: begin
                    hash_reg[init_reg[2:0]] <= init_h(init_reg[2:0]);
                    init_reg <= init_reg + 4'd1;
                    if (init_reg == 4'd7) begin
                        init_reg <= '0;
                        fill_reg <= '0;
                        len_reg <= '0;
                        done_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (acc) begin
                        unique case (mode_t'(s_tuser))
                            MODE_ABSORB: if (!done_reg) begin
                                fill_reg <= fill_reg + 6'd1;
                                len_reg <= len_reg + 61'd1;
                                if (fill_reg == 6'd63) begin
                                    closing_reg <= 1'b0;
                                    state_reg <= ST_COMP;
                                end
                            end
                            MODE_FINALIZE: begin
                                idx_reg <= '0;
                                if (done_reg) state_reg <= ST_EMIT;
                                else begin
                                    pos_reg <= fill_reg;
                                    final_reg <= 1'b0;
                                    closing_reg <= 1'b1;
                                    state_reg <= ST_PAD;
                                end
                            end
                            MODE_RESTART: state_reg <= ST_INIT;
                            default: ;
                        endcase
                    end
                end
                ST_PAD: begin
                    pos_reg <= pos_reg + 6'd1;
                    if (!final_reg && pos_reg == 6'd55 && fill_reg < 6'd56) final_reg <= 1'b1;
                    else if (pos_reg == 6'd63) begin
                        // Block of padding complete: compress it
                        state_reg <= ST_COMP;
                    end
                end
                ST_COMP: begin
                    rcnt_reg <= '0;
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    rcnt_reg <= rcnt_reg + 6'd1;
                    if (rstat.done) state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) hash_reg[i] <= hash_reg[i] + work[i];
                    if (!closing_reg) state_reg <= ST_IDLE;
                    else if (!final_reg) begin
                        // Marker did not leave room for the length
                        final_reg <= 1'b1;
                        pos_reg <= '0;
                        state_reg <= ST_PAD;
                    end else begin
                        fill_reg <= '0;
                        done_reg <= 1'b1;
                        idx_reg <= '0;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (m_tready) begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7) state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = {5'd0, idx_reg, hash_reg[idx_reg]};
    assign m_tlast  = (idx_reg == 3'd7);

    // Input is held off while results are pending
    a_no_ready_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("ready during digest output");
    // Round unit only finishes while the sequencer waits on it
    a_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        rstat.done |-> state_reg == ST_WAIT) else $error("stray round done");
    // Digest output only after the message is closed
    a_emit_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> done_reg) else $error("digest before close");

endmodule

// File: bench/sha256_stream_hasher_tb.sv
// Testbench: streams bytes and commands into the SHA-256 hasher and checks digest items.
`timescale 1ns / 100ps

module sha256_stream_hasher_tb;
    import sha_pkg::*;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] data_byte;
    } cmd_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_item_t;

    localparam logic [31:0] RK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic [1:0]  s_tuser;   // [1:0] mode
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [31:0] digest_word, [34:32] word_index, zero fill
    logic        m_tlast;   // last_word

    sha256_stream_hasher i_dut (.*);

    // Predictor state
    logic [31:0] hv [8];
    logic [7:0]  blk [64];
    logic [5:0]  fill;
    logic [60:0] msg_len;
    logic        closed;

    cmd_item_t    cmd_q [$];
    digest_item_t digest_q [$];
    int           errors;
    int           n_digests;
    int           n_absorbed;
    int           sender_idle_pct;
    int           receiver_stall_pct;
    bit           hold_sender;
    bit           in_taken;

    function automatic logic [31:0] rr(logic [31:0] v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // Fold the block store into the running hash
    function automatic void compress_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10));
        {a, b, c, d, e, f, g, h} = {hv[0], hv[1], hv[2], hv[3], hv[4], hv[5], hv[6], hv[7]};
        for (int i = 0; i < 64; i++) begin
            t1 = h + (rr(e, 6) ^ rr(e, 11) ^ rr(e, 25)) + ((e & f) ^ (~e & g)) + RK[i] + w[i];
            t2 = (rr(a, 2) ^ rr(a, 13) ^ rr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d;
        hv[4] += e; hv[5] += f; hv[6] += g; hv[7] += h;
    endfunction

    function automatic void start_message();
        for (int i = 0; i < 8; i++) hv[i] = IV[i];
        fill = '0;
        msg_len = '0;
        closed = 1'b0;
    endfunction

    // Advance the predictor by one accepted item and queue the digest it causes
    function automatic void predict_digest(cmd_item_t it);
        logic [63:0] bits;
        int pos;
        case (it.mode)
            MODE_ABSORB: begin
                if (!closed) begin
                    blk[fill] = it.data_byte;
                    fill++;
                    msg_len++;
                    if (fill == 0) compress_block();
                end
            end
            MODE_RESTART: start_message();
            MODE_FINALIZE: begin
                if (!closed) begin
                    bits = {msg_len, 3'b000};
                    pos = fill;
                    blk[pos] = 8'h80;
                    pos++;
                    if (pos > 56) begin
                        while (pos < 64) begin
                            blk[pos] = 8'h00;
                            pos++;
                        end
                        compress_block();
                        pos = 0;
                    end
                    while (pos < 56) begin
                        blk[pos] = 8'h00;
                        pos++;
                    end
                    for (int i = 0; i < 8; i++) blk[56+i] = bits[(7-i)*8 +: 8];
                    compress_block();
                    fill = '0;
                    closed = 1'b1;
                end
                for (int k = 0; k < 8; k++)
                    digest_q.push_back('{hv[k], 3'(k), k == 7});
            end
            default: ;
        endcase
    endfunction

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Drive items from the pending queue at the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_taken) begin
            // hold the item until accepted
        end else if (cmd_q.size() > 0 && !hold_sender &&
                     $urandom_range(99, 0) >= sender_idle_pct) begin
            s_tvalid <= 1'b1;
            s_tuser  <= cmd_q[0].mode;
            s_tdata  <= cmd_q[0].data_byte;
            cmd_q.pop_front();
        end else begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tuser  <= 2'($urandom);
        end
        m_tready <= ($urandom_range(99, 0) >= receiver_stall_pct);
    end

    // Predict on accepted items, check accepted digest items
    always @(posedge aclk) begin
        in_taken = aresetn && s_tvalid && s_tready;
        if (in_taken) begin
            predict_digest('{mode_t'(s_tuser), s_tdata});
            if (s_tuser == MODE_ABSORB && !closed) n_absorbed++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            n_digests++;
            if (digest_q.size() == 0) begin
                $error("digest item with nothing expected: %h", m_tdata);
                errors++;
            end else begin
                if (m_tdata[31:0] !== digest_q[0].digest_word) begin
                    $error("digest_word: expected %h, got %h",
                           digest_q[0].digest_word, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[34:32] !== digest_q[0].word_index) begin
                    $error("word_index: expected %0d, got %0d",
                           digest_q[0].word_index, m_tdata[34:32]);
                    errors++;
                end
                if (m_tlast !== digest_q[0].last_word) begin
                    $error("last_word: expected %0b, got %0b",
                           digest_q[0].last_word, m_tlast);
                    errors++;
                end
                digest_q.pop_front();
            end
        end
    end

    task automatic push_cmd(mode_t m, logic [7:0] d);
        cmd_q.push_back('{m, d});
    endtask

    // Wait until every queued item has gone in and every digest has come out
    task automatic drain();
        while (cmd_q.size() > 0 || s_tvalid || digest_q.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    // One random message: restart, then len items that are mostly absorbs, then finalize
    task automatic queue_message(int len);
        int r;
        push_cmd(MODE_RESTART, 8'($urandom));
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(99, 0);
            if (r < 2) push_cmd(MODE_UNUSED, 8'($urandom));
            else push_cmd(MODE_ABSORB, 8'($urandom));
        end
        push_cmd(MODE_FINALIZE, 8'($urandom));
        if ($urandom_range(3, 0) == 0) push_cmd(MODE_ABSORB, 8'($urandom));
        if ($urandom_range(3, 0) == 0) push_cmd(MODE_FINALIZE, 8'($urandom));
    endtask

    initial begin
        int plen;
        errors = 0; n_digests = 0; n_absorbed = 0;
        sender_idle_pct = 0; receiver_stall_pct = 0;
        hold_sender = 1'b0; in_taken = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0; m_tready = 1'b0;
        aresetn = 1'b0;
        start_message();
        repeat (5) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Directed: empty message, extremes, repeated finalize, ignored items
        push_cmd(MODE_FINALIZE, 8'h00);
        push_cmd(MODE_FINALIZE, 8'hff);
        push_cmd(MODE_ABSORB, 8'hff);
        push_cmd(MODE_RESTART, 8'h00);
        push_cmd(MODE_ABSORB, 8'h00);
        push_cmd(MODE_ABSORB, 8'hff);
        push_cmd(MODE_UNUSED, 8'h5a);
        push_cmd(MODE_ABSORB, 8'ha5);
        push_cmd(MODE_FINALIZE, 8'h00);
        push_cmd(MODE_RESTART, 8'hff);
        drain();

        // Hold the sender back while a message is queued, then release it
        hold_sender = 1'b1;
        queue_message(3);
        repeat (20) @(posedge aclk);
        hold_sender = 1'b0;
        drain();

        // Random messages over four phases of sender idling and receiver stalls; lengths cross
        // the block and padding boundaries (55, 56, 63, 64, 119 to 128)
        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct    = (ph == 1 || ph == 3) ? 57 : 0;
            receiver_stall_pct = (ph == 2) ? 57 : (ph == 3) ? 22 : 0;
            if (ph == 3) sender_idle_pct = 22;
            for (int m = 0; m < 2; m++) begin
                case ($urandom_range(5, 0))
                    0: plen = 55;
                    1: plen = 56;
                    2: plen = 63 + $urandom_range(1, 0);
                    3: plen = 119 + $urandom_range(9, 0);
                    default: plen = $urandom_range(20, 0);
                endcase
                queue_message(plen);
            end
            drain();
        end

        $display("Hashed messages of 0 to 128 bytes, %0d bytes absorbed, %0d digest items",
                 n_absorbed, n_digests);
        $display("checked under sender idling, receiver stalls and both together");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sha256_stream_hasher.f
src/sha_pkg.sv
src/sha_round.sv
src/sha_ram.sv
src/sha256_stream_hasher.sv
bench/sha256_stream_hasher_tb.sv
